// File: rtl/cis_pkg.sv
package cis_pkg;

	// Pattern characters held by the configuration registers
	localparam int unsigned PATTERN_CHARS = 32;
	localparam int unsigned LEN_W = 6;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_last;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [15:0] match_start;
		logic        position_overflow;
	} out_item_t;

	// Per-item control carried from the input stage to the compare stage
	typedef struct packed {
		logic valid;
		logic last;
		logic overflow;
	} s1_ctrl_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

	function automatic logic [7:0][7:0] fold_word(input logic [CFG_DATA_W-1:0] w);
		logic [7:0][7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[k] = fold_case(w[8*k +: 8]);
		end
		return r;
	endfunction

endpackage

// File: rtl/cis_cfg.sv
module cis_cfg #(
	parameter int unsigned WIN = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [cis_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cis_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic [WIN-1:0][7:0]                   aligned_pattern,
	output logic [WIN-1:0]                        pattern_mask,
	output logic [cis_pkg::LEN_W-1:0]             used_length
);

	logic [cis_pkg::LEN_W-1:0]                    len_q;
	logic [cis_pkg::PATTERN_CHARS-1:0][7:0]       pat_q;
	logic [cis_pkg::PATTERN_CHARS-1:0][7:0]       rev;
	logic [cis_pkg::PATTERN_CHARS-1:0][7:0]       shifted;
	logic [cis_pkg::LEN_W-1:0]                    gap;
	logic [cis_pkg::LEN_W+2:0]                    shift_bits;
	logic [WIN-1:0][7:0]                          ap_q;
	logic [WIN-1:0]                               mask_q;

	// Pattern is stored already folded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pat_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cis_pkg::REG_PATTERN_LENGTH: len_q <= cfg_data[cis_pkg::LEN_W-1:0];
				cis_pkg::REG_PATTERN_WORD_0: pat_q[7:0] <= cis_pkg::fold_word(cfg_data);
				cis_pkg::REG_PATTERN_WORD_1: pat_q[15:8] <= cis_pkg::fold_word(cfg_data);
				cis_pkg::REG_PATTERN_WORD_2: pat_q[23:16] <= cis_pkg::fold_word(cfg_data);
				cis_pkg::REG_PATTERN_WORD_3: pat_q[31:24] <= cis_pkg::fold_word(cfg_data);
				default: ;
			endcase
		end
	end

	assign used_length = (len_q > cis_pkg::LEN_W'(WIN)) ? cis_pkg::LEN_W'(WIN) : len_q;

	// Align the pattern to the window: entry i faces character len-1-i
	always_comb begin
		for (int i = 0; i < cis_pkg::PATTERN_CHARS; i++) begin
			rev[i] = pat_q[cis_pkg::PATTERN_CHARS-1-i];
		end
		gap = cis_pkg::LEN_W'(cis_pkg::PATTERN_CHARS) - used_length;
		shift_bits = {gap, 3'b000};
		shifted = rev >> shift_bits;
	end

	always_ff @(posedge clk) begin
		ap_q <= shifted[WIN-1:0];
		for (int i = 0; i < WIN; i++) begin
			mask_q[i] <= (cis_pkg::LEN_W'(i) < used_length);
		end
	end

	assign aligned_pattern = ap_q;
	assign pattern_mask = mask_q;

endmodule

// File: rtl/cis_front.sv
module cis_front #(
	parameter int unsigned     WIN = 32,
	parameter int unsigned     POS_W = 16,
	parameter longint unsigned TEXT_MAX = 65535
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cis_pkg::in_item_t     in_data,
	input  logic                  advance,
	output cis_pkg::s1_ctrl_t     ctrl_s1,
	output logic [POS_W-1:0]      pos_s1,
	output logic [WIN-1:0][7:0]   window_s1
);

	localparam logic [POS_W-1:0] TMAX = POS_W'(TEXT_MAX);

	logic               accept;
	logic               at_max;
	logic [POS_W-1:0]   pos_q;
	logic               ovf_q;
	logic [POS_W-1:0]   pos_next;
	logic               ovf_next;
	logic               valid_s1;
	logic               last_s1;
	logic               ovf_s1;
	logic [POS_W-1:0]   pos_reg_s1;
	logic [WIN-1:0][7:0] win_s1;

	assign in_ready = !valid_s1 || advance;
	assign accept = in_valid && in_ready;

	// Saturate the byte count and remember that it did
	assign at_max = (pos_q >= TMAX);
	assign pos_next = at_max ? pos_q : pos_q + POS_W'(1);
	assign ovf_next = ovf_q || at_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				pos_q <= in_data.text_last ? '0 : pos_next;
				ovf_q <= in_data.text_last ? 1'b0 : ovf_next;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= in_data.text_last;
			ovf_s1 <= ovf_next;
			pos_reg_s1 <= pos_next;
			win_s1[0] <= cis_pkg::fold_case(in_data.text_byte);
			for (int i = 1; i < WIN; i++) begin
				win_s1[i] <= win_s1[i-1];
			end
		end
	end

	assign ctrl_s1 = '{valid: valid_s1, last: last_s1, overflow: ovf_s1};
	assign pos_s1 = pos_reg_s1;
	assign window_s1 = win_s1;

endmodule

// File: rtl/cis_match.sv
module cis_match #(
	parameter int unsigned WIN = 32,
	parameter int unsigned POS_W = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cis_pkg::s1_ctrl_t          ctrl_s1,
	input  logic [POS_W-1:0]           pos_s1,
	input  logic [WIN-1:0][7:0]        window_s1,
	input  logic [WIN-1:0][7:0]        aligned_pattern,
	input  logic [WIN-1:0]             pattern_mask,
	input  logic [cis_pkg::LEN_W-1:0]  used_length,
	output logic                       advance,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cis_pkg::out_item_t         out_data
);

	localparam int unsigned SW = (POS_W > 16) ? POS_W : 16;

	logic [WIN-1:0]      eq;
	logic                hit;
	logic [SW-1:0]       diff;
	logic [15:0]         start;
	logic                produce;
	logic                reported_q;
	logic                valid_s2;
	cis_pkg::out_item_t  data_s2;

	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			eq[i] = !pattern_mask[i] || (window_s1[i] == aligned_pattern[i]);
		end
	end

	assign hit = (used_length == '0) ||
		((pos_s1 >= POS_W'(used_length)) && (&eq));
	assign diff = SW'(pos_s1 - POS_W'(used_length));
	assign start = (used_length == '0) ? 16'h0000 :
		((diff > SW'(17'h0FFFF)) ? 16'hFFFF : diff[15:0]);

	assign advance = ctrl_s1.valid && (!valid_s2 || out_ready);
	assign produce = !reported_q && (hit || ctrl_s1.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			reported_q <= 1'b0;
		end else if (advance) begin
			valid_s2 <= produce;
			reported_q <= ctrl_s1.last ? 1'b0 : (reported_q || hit);
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2.found <= hit;
			data_s2.match_start <= hit ? start : 16'h0000;
			data_s2.position_overflow <= ctrl_s1.overflow;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = data_s2;

endmodule

// File: rtl/case_insensitive_substring_search_core.sv
// Case-insensitive streaming substring search. Text arrives one byte per
// transaction on the input channel, with text_last marking the final byte of
// each text; letters a-z are folded to A-Z before comparison and every other
// byte, zero included, compares as it is. For each text the block returns
// exactly one result: found with the start offset on the byte that completes
// the first match (later bytes of that text are then ignored), or not-found on
// the last byte. An empty pattern matches at offset 0 on the first byte. The
// byte count saturates at TEXT_MAX and position_overflow is raised from then
// on; a start offset is capped at 65535. Up to 32 pattern characters are used,
// fewer when PATTERN_MAX is smaller. Throughput is one byte per clock while
// results are taken as they come; a byte sits in the input register while
// the parallel window compare feeds the result register, which holds its
// result. Write the pattern registers only while no transaction is in
// flight; the new pattern is ready for a byte accepted on the next cycle.
module case_insensitive_substring_search_core #(
	parameter int unsigned     PATTERN_MAX = 32,
	parameter longint unsigned TEXT_MAX = 65535
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  cis_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output cis_pkg::out_item_t             out_data,
	input  logic                           cfg_wr_en,
	input  logic [cis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cis_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Window depth: only as many entries as a pattern can use
	localparam int unsigned WIN = (PATTERN_MAX < cis_pkg::PATTERN_CHARS) ?
		PATTERN_MAX : cis_pkg::PATTERN_CHARS;
	localparam int unsigned POS_W = $clog2(TEXT_MAX + 64'd1);

	logic [WIN-1:0][7:0]        aligned_pattern;
	logic [WIN-1:0]             pattern_mask;
	logic [cis_pkg::LEN_W-1:0]  used_length;
	logic                       advance;
	cis_pkg::s1_ctrl_t          ctrl_s1;
	logic [POS_W-1:0]           pos_s1;
	logic [WIN-1:0][7:0]        window_s1;

	// Pattern registers, folded and pre-aligned to the window
	cis_cfg #(
		.WIN (WIN)
	) u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.aligned_pattern (aligned_pattern),
		.pattern_mask    (pattern_mask),
		.used_length     (used_length)
	);

	// Input register: shift the folded byte into the window, advance the count
	cis_front #(
		.WIN      (WIN),
		.POS_W    (POS_W),
		.TEXT_MAX (TEXT_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.advance   (advance),
		.ctrl_s1   (ctrl_s1),
		.pos_s1    (pos_s1),
		.window_s1 (window_s1)
	);

	// Window compare, report tracking and result register
	cis_match #(
		.WIN   (WIN),
		.POS_W (POS_W)
	) u_match (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl_s1         (ctrl_s1),
		.pos_s1          (pos_s1),
		.window_s1       (window_s1),
		.aligned_pattern (aligned_pattern),
		.pattern_mask    (pattern_mask),
		.used_length     (used_length),
		.advance         (advance),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data)
	);

endmodule

// File: tb/sv/case_insensitive_substring_search_core_test.sv
module case_insensitive_substring_search_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Longest stretch of cycles with no transaction on any port before the run is abandoned
	localparam int unsigned STALL_LIMIT = 5000;
	// Cycles to let a byte that yields no outcome clear the two-stage pipeline
	localparam int unsigned SETTLE_CYCLES = 8;
	// Bytes per pattern setting in the random part
	localparam int unsigned BYTES_PER_SETTING = 140;

	// Tracks the search state of the block and holds the outcomes still to come out of it
	class search_scoreboard;
		localparam int unsigned WINDOW_DEPTH = 32;
		localparam int unsigned TEXT_LIMIT = 65535;

		bit [5:0]  length_reg;
		bit [63:0] words[4];
		bit [7:0]  window[WINDOW_DEPTH];
		int unsigned position;
		bit overflowed;
		bit reported;
		cis_pkg::out_item_t awaited_outcomes[$];
		int unsigned mismatches;

		function logic [7:0] upcase(input logic [7:0] c);
			if (c >= 8'h61 && c <= 8'h7A) begin
				return c - 8'h20;
			end
			return c;
		endfunction

		function int unsigned active_len();
			return (length_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : length_reg;
		endfunction

		function logic [7:0] pattern_char(input int unsigned k);
			return upcase(words[k / 8][8 * (k % 8) +: 8]);
		endfunction

		function void write_reg(input logic [cis_pkg::CFG_IDX_W-1:0] idx,
					input logic [63:0] d);
			case (idx)
				cis_pkg::REG_PATTERN_LENGTH: length_reg = d[5:0];
				cis_pkg::REG_PATTERN_WORD_0: words[0] = d;
				cis_pkg::REG_PATTERN_WORD_1: words[1] = d;
				cis_pkg::REG_PATTERN_WORD_2: words[2] = d;
				cis_pkg::REG_PATTERN_WORD_3: words[3] = d;
				default: ;
			endcase
		endfunction

		// Shift in one accepted byte and work out the outcome it causes, if any
		function void advance_search(input cis_pkg::in_item_t item);
			cis_pkg::out_item_t outcome;
			int unsigned n;
			int unsigned start;
			bit hit;
			n = active_len();
			for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
				window[i] = window[i-1];
			end
			window[0] = upcase(item.text_byte);
			if (position >= TEXT_LIMIT) begin
				overflowed = 1'b1;
			end else begin
				position++;
			end
			if (!reported) begin
				hit = 1'b0;
				start = 0;
				if (n == 0) begin
					hit = 1'b1;
				end else if (position >= n) begin
					hit = 1'b1;
					for (int i = 0; i < n; i++) begin
						if (window[i] != pattern_char(n - 1 - i)) begin
							hit = 1'b0;
						end
					end
					start = position - n;
				end
				if (start > 16'hFFFF) begin
					start = 16'hFFFF;
				end
				if (hit || item.text_last) begin
					outcome.found = hit;
					outcome.match_start = hit ? start[15:0] : 16'd0;
					outcome.position_overflow = overflowed;
					awaited_outcomes.push_back(outcome);
					reported = hit;
				end
			end
			if (item.text_last) begin
				position = 0;
				overflowed = 1'b0;
				reported = 1'b0;
			end
		endfunction

		task flag_mismatch(input string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_outcome(input cis_pkg::out_item_t got);
			cis_pkg::out_item_t want;
			if (awaited_outcomes.size() == 0) begin
				flag_mismatch($sformatf("unexpected result found=%0b start=%0d ovf=%0b",
					got.found, got.match_start, got.position_overflow));
				return;
			end
			want = awaited_outcomes.pop_front();
			if (got.found !== want.found) begin
				flag_mismatch($sformatf("found %0b, expected %0b", got.found, want.found));
			end
			if (got.match_start !== want.match_start) begin
				flag_mismatch($sformatf("match_start %0d, expected %0d",
					got.match_start, want.match_start));
			end
			if (got.position_overflow !== want.position_overflow) begin
				flag_mismatch($sformatf("position_overflow %0b, expected %0b",
					got.position_overflow, want.position_overflow));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	cis_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	cis_pkg::out_item_t out_data;
	logic cfg_wr_en;
	logic [cis_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cis_pkg::CFG_DATA_W-1:0] cfg_data;

	search_scoreboard sb;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned quiet_cycles = 0;

	case_insensitive_substring_search_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result channel at random; the rate changes from phase to phase
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sample both channels at the rising edge: predict on every accepted byte, check
	// every accepted result against the oldest outstanding outcome
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.advance_search(in_data);
			end
			if (out_valid && out_ready) begin
				sb.check_outcome(out_data);
			end
		end
	end

	// Watchdog: give up once no transaction of any kind has happened for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Offer one byte, with a random idle gap first, and hold it until the block takes it.
	// Call and return at a falling edge; valid is left high so that a following byte
	// goes out back to back.
	task automatic send_byte(input logic [7:0] b, input logic tail);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{text_byte: b, text_last: tail};
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] txt[$]);
		foreach (txt[i]) begin
			send_byte(txt[i], i == txt.size() - 1);
		end
	endtask

	// Drop valid, wait for every outstanding outcome, then let the pipeline drain
	// of bytes that produce none
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.awaited_outcomes.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [cis_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.write_reg(idx, d);
		@(negedge clk);
	endtask

	// Write all five registers; the length goes in with junk in the unused upper bits
	task automatic load_pattern(input int unsigned plen, input logic [63:0] w0, w1, w2, w3);
		logic [63:0] lenword;
		lenword = {$urandom, $urandom};
		lenword[5:0] = plen[5:0];
		write_reg(cis_pkg::REG_PATTERN_LENGTH, lenword);
		write_reg(cis_pkg::REG_PATTERN_WORD_0, w0);
		write_reg(cis_pkg::REG_PATTERN_WORD_1, w1);
		write_reg(cis_pkg::REG_PATTERN_WORD_2, w2);
		write_reg(cis_pkg::REG_PATTERN_WORD_3, w3);
		cfg_wr_en <= 1'b0;
	endtask

	// Pattern word, biased towards letters of either case when letters is set, so folding is exercised
	function automatic logic [63:0] random_word(input bit letters);
		logic [63:0] w;
		for (int k = 0; k < 8; k++) begin
			if (letters && $urandom_range(99) < 60) begin
				w[8*k +: 8] = 8'h41 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h20 : 8'h00);
			end else begin
				w[8*k +: 8] = 8'($urandom_range(255));
			end
		end
		return w;
	endfunction

	// Letters come out in either case; everything else as it is
	function automatic logic [7:0] vary_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A && $urandom_range(1)) begin
			return c + 8'h20;
		end
		return c;
	endfunction

	function automatic logic [7:0] filler_byte(input int unsigned plen);
		if (plen > 0 && $urandom_range(1)) begin
			return vary_case(sb.pattern_char($urandom_range(plen - 1)));
		end
		return 8'($urandom_range(255));
	endfunction

	// One text: mostly the pattern planted at a random offset in random case, some with
	// one character spoiled, the rest plain noise
	task automatic send_random_text(output int unsigned count);
		logic [7:0] body[$];
		logic [7:0] b;
		int unsigned plen, n, kind, at, k;
		plen = sb.active_len();
		n = $urandom_range(1, 40);
		kind = $urandom_range(99);
		if (kind < 85 && n < plen) begin
			n = plen + $urandom_range(0, 4);
		end
		for (int i = 0; i < n; i++) begin
			body.push_back(filler_byte(plen));
		end
		if (kind < 85 && plen > 0) begin
			at = $urandom_range(0, n - plen);
			for (int i = 0; i < plen; i++) begin
				body[at + i] = vary_case(sb.pattern_char(i));
			end
			if (kind >= 60) begin
				k = $urandom_range(plen - 1);
				do begin
					b = 8'($urandom_range(255));
				end while (sb.upcase(b) == sb.pattern_char(k));
				body[at + k] = b;
			end
		end
		send_text(body);
		count = n;
	endtask

	task automatic run_directed();
		// Empty pattern after reset: hit at offset 0 on the first byte, rest ignored
		send_text('{8'h51});
		send_text('{8'h61, 8'h62});
		settle();
		// Pattern "aZ", NUL, 0xFF: lower case in the register, zero and top byte in it
		load_pattern(4, {$urandom, 32'hFF005A61}, random_word(1), random_word(1),
			random_word(1));
		// Hit at offset 1, trailing byte ignored
		send_text('{8'h78, 8'h41, 8'h7A, 8'h00, 8'hFF, 8'h71});
		// Text ends one character short
		send_text('{8'h41, 8'h5A, 8'h00});
		// Completing byte arrives in the next text: must not match across the boundary
		send_text('{8'hFF});
		// Characters either side of the letter ranges are left as they are
		send_text('{8'h60, 8'h7B, 8'h40, 8'h5B, 8'h61, 8'h7A, 8'h00, 8'hFF});
		settle();
	endtask

	initial begin
		int unsigned plan_len[12];
		logic [63:0] w[4];
		int unsigned sent, chunk, setting;
		sb = new;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		// Lengths above 32 are capped by the block; zero is the empty pattern
		plan_len = '{0, 1, 32, 63, 5, 2, 33, 17, 8, 31, 3, 12};
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();

		// Random part in three idling regimes: receiver sparse, sender sparse, neither
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 20;
					recv_idle_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_idle_pct = 20;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < 4; s++) begin
				setting = 4 * mode + s;
				for (int k = 0; k < 4; k++) begin
					case (setting)
						1: w[k] = '0;
						2: w[k] = '1;
						3: w[k] = random_word(0);
						default: w[k] = random_word(1);
					endcase
				end
				load_pattern(plan_len[setting], w[0], w[1], w[2], w[3]);
				sent = 0;
				while (sent < BYTES_PER_SETTING) begin
					send_random_text(chunk);
					sent += chunk;
				end
				settle();
			end
		end

		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/cis_pkg.sv
rtl/cis_cfg.sv
rtl/cis_front.sv
rtl/cis_match.sv
rtl/case_insensitive_substring_search_core.sv
tb/sv/case_insensitive_substring_search_core_test.sv
